>>> src/css_pkg.sv
// cursor sequence store package: request and status codes, plan codes,
// and the command and status structs between controller and datapath.
// no dependencies; imported by css_ctrl, css_datapath and the top level.
`timescale 1ns / 1ps

package css_pkg;

  // request codes carried in the input tuser
  localparam logic [2:0] REQ_START   = 3'd0;
  localparam logic [2:0] REQ_ADVANCE = 3'd1;
  localparam logic [2:0] REQ_INSERT  = 3'd2;
  localparam logic [2:0] REQ_ATTACH  = 3'd3;
  localparam logic [2:0] REQ_REMOVE  = 3'd4;
  localparam logic [2:0] REQ_READ    = 3'd5;

  // result status codes carried in the output tuser
  localparam logic [1:0] ST_OK     = 2'd0;
  localparam logic [1:0] ST_FULL   = 2'd1;
  localparam logic [1:0] ST_NOITEM = 2'd2;

  // fixed port field widths
  localparam int unsigned REQ_BITS   = 3;
  localparam int unsigned ENTRY_BITS = 32;
  localparam int unsigned COUNT_BITS = 6;
  localparam int unsigned IN_TDATA_BITS  = 32;
  localparam int unsigned OUT_TDATA_BITS = 40;

  // shift work decided when a beat is taken
  typedef enum logic [1:0] {
    PLAN_NONE = 2'd0,
    PLAN_UP   = 2'd1,
    PLAN_DN   = 2'd2
  } plan_t;

  // controller to datapath commands
  typedef struct packed {
    logic accept;    // input beat taken this cycle
    logic rd_shift;  // read the source entry of a shift step
    logic wr_shift;  // write the shifted entry and step the index
    logic wr_put;    // write the new value at the cursor
    logic rd_cur;    // read the entry under the cursor
    logic load_out;  // load the output register
  } dp_cmd_t;

  // datapath to controller status
  typedef struct packed {
    plan_t plan;       // shift work of the current request
    logic  loop_more;  // entries still to be moved
    logic  out_free;   // output register can take a result
  } dp_stat_t;

endpackage

>>> src/css_datapath.sv
// cursor sequence store datapath: item memory, count, cursor, shift index,
// request decode and the output register.
// depends on css_pkg.
`timescale 1ns / 1ps

module css_datapath #(
  parameter int unsigned DEPTH      = 32,
  parameter int unsigned VALUE_BITS = 32
) (
  input  logic                                clk,
  input  logic                                rst_n,
  input  css_pkg::dp_cmd_t                    cmd,
  output css_pkg::dp_stat_t                   stat,
  input  logic [css_pkg::IN_TDATA_BITS-1:0]   in_tdata,   // entry_value[31:0]
  input  logic [css_pkg::REQ_BITS-1:0]        in_tuser,   // req_type[2:0]
  output logic                                out_tvalid,
  input  logic                                out_tready,
  // current_value[31:0], has_item[32], item_count[38:33], zero pad[39]
  output logic [css_pkg::OUT_TDATA_BITS-1:0]  out_tdata,
  output logic [1:0]                          out_tuser   // status[1:0]
);
  import css_pkg::*;

  localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CW = $clog2(DEPTH + 1);

  // item memory
  logic [VALUE_BITS-1:0] mem [DEPTH];
  logic [VALUE_BITS-1:0] rdata_r;

  // architectural and working registers
  logic [CW-1:0]         count_r, count_nxt;
  logic [CW-1:0]         cursor_r, cursor_nxt;
  logic [CW-1:0]         idx_r, idx_nxt;
  logic [CW-1:0]         bound_r, bound_nxt;
  logic [1:0]            status_r, status_nxt;
  plan_t                 plan_r, plan_nxt;
  logic [VALUE_BITS-1:0] value_r;

  // output register
  logic                  out_valid_r;
  logic [ENTRY_BITS-1:0] out_value_r;
  logic                  out_has_r;
  logic [COUNT_BITS-1:0] out_count_r;
  logic [1:0]            out_status_r;

  logic          cur_valid;
  logic          full;
  logic [CW-1:0] idx_m1;
  logic          wr_en;
  logic          rd_en;
  logic [AW-1:0] waddr;
  logic [AW-1:0] raddr;
  logic [VALUE_BITS-1:0] wdata;

  assign cur_valid = cursor_r < count_r;
  assign full      = count_r == CW'(DEPTH);
  assign idx_m1    = idx_r - CW'(1);

  // request decode at the accepted beat, shift index stepping otherwise
  always_comb begin
    count_nxt  = count_r;
    cursor_nxt = cursor_r;
    idx_nxt    = idx_r;
    bound_nxt  = bound_r;
    status_nxt = status_r;
    plan_nxt   = plan_r;
    if (cmd.accept) begin
      status_nxt = ST_OK;
      plan_nxt   = PLAN_NONE;
      case (in_tuser)
        REQ_START: begin
          cursor_nxt = '0;
        end
        REQ_ADVANCE: begin
          if (cur_valid) cursor_nxt = cursor_r + CW'(1);
          else status_nxt = ST_NOITEM;
        end
        REQ_INSERT: begin
          if (full) begin
            status_nxt = ST_FULL;
          end else begin
            cursor_nxt = cur_valid ? cursor_r : '0;
            count_nxt  = count_r + CW'(1);
            plan_nxt   = PLAN_UP;
            idx_nxt    = count_r;
            bound_nxt  = cur_valid ? cursor_r : '0;
          end
        end
        REQ_ATTACH: begin
          if (full) begin
            status_nxt = ST_FULL;
          end else begin
            cursor_nxt = cur_valid ? cursor_r + CW'(1) : count_r;
            count_nxt  = count_r + CW'(1);
            plan_nxt   = PLAN_UP;
            idx_nxt    = count_r;
            bound_nxt  = cur_valid ? cursor_r + CW'(1) : count_r;
          end
        end
        REQ_REMOVE: begin
          if (!cur_valid) begin
            status_nxt = ST_NOITEM;
          end else begin
            count_nxt = count_r - CW'(1);
            plan_nxt  = PLAN_DN;
            idx_nxt   = cursor_r + CW'(1);
            bound_nxt = count_r;
          end
        end
        REQ_READ: begin
          if (!cur_valid) status_nxt = ST_NOITEM;
        end
        default: begin
        end
      endcase
    end else if (cmd.wr_shift) begin
      idx_nxt = (plan_r == PLAN_UP) ? idx_m1 : idx_r + CW'(1);
    end
  end

  // control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r  <= '0;
      cursor_r <= '0;
      idx_r    <= '0;
      bound_r  <= '0;
      status_r <= ST_OK;
      plan_r   <= PLAN_NONE;
    end else begin
      count_r  <= count_nxt;
      cursor_r <= cursor_nxt;
      idx_r    <= idx_nxt;
      bound_r  <= bound_nxt;
      status_r <= status_nxt;
      plan_r   <= plan_nxt;
    end
  end

  // captured entry value, masked to the stored width
  always_ff @(posedge clk) begin
    if (cmd.accept) value_r <= VALUE_BITS'(in_tdata[ENTRY_BITS-1:0]);
  end

  // memory address and data selection
  always_comb begin
    wr_en = cmd.wr_shift | cmd.wr_put;
    rd_en = cmd.rd_shift | cmd.rd_cur;
    wdata = cmd.wr_put ? value_r : rdata_r;
    if (cmd.wr_put) waddr = cursor_r[AW-1:0];
    else if (plan_r == PLAN_UP) waddr = idx_r[AW-1:0];
    else waddr = idx_m1[AW-1:0];
    if (cmd.rd_cur) raddr = cursor_r[AW-1:0];
    else if (plan_r == PLAN_UP) raddr = idx_m1[AW-1:0];
    else raddr = idx_r[AW-1:0];
  end

  // item memory, one write and one registered read per cycle
  always_ff @(posedge clk) begin
    if (wr_en) mem[waddr] <= wdata;
    if (rd_en) rdata_r <= mem[raddr];
  end

  // output register, freed when the receiver takes the beat
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.load_out) begin
      out_valid_r <= 1'b1;
    end else if (out_tready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load_out) begin
      out_value_r  <= cur_valid ? ENTRY_BITS'(rdata_r) : '0;
      out_has_r    <= cur_valid;
      out_count_r  <= COUNT_BITS'(count_r);
      out_status_r <= status_r;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {1'b0, out_count_r, out_has_r, out_value_r};
  assign out_tuser  = out_status_r;

  assign stat.plan      = plan_r;
  assign stat.loop_more = idx_r != bound_r;
  assign stat.out_free  = !out_valid_r || out_tready;

`ifndef NO_ASSERTIONS
  a_cursor_in_range: assert property (@(posedge clk) disable iff (!rst_n)
    cursor_r <= count_r)
    else $error("cursor beyond item count");

  a_count_in_range: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= CW'(DEPTH))
    else $error("item count beyond depth");

  a_up_shift_above_bound: assert property (@(posedge clk) disable iff (!rst_n)
    (cmd.wr_shift && plan_r == PLAN_UP) |-> idx_r > bound_r)
    else $error("upward shift below insertion point");

  a_load_needs_slot: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.load_out |-> (!out_valid_r || out_tready))
    else $error("output register overwritten");
`endif

endmodule

>>> src/css_ctrl.sv
// cursor sequence store controller: one-hot sequencer that takes a beat,
// runs the shift loop over the item memory and hands the result over.
// depends on css_pkg.
`timescale 1ns / 1ps

module css_ctrl (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_tvalid,
  output logic               in_tready,
  input  css_pkg::dp_stat_t  stat,
  output css_pkg::dp_cmd_t   cmd
);
  import css_pkg::*;

  typedef enum logic [7:0] {
    S_IDLE  = 8'b0000_0001,
    S_PLAN  = 8'b0000_0010,
    S_UP_RD = 8'b0000_0100,
    S_UP_WR = 8'b0000_1000,
    S_PUT   = 8'b0001_0000,
    S_DN_RD = 8'b0010_0000,
    S_DN_WR = 8'b0100_0000,
    S_RESP  = 8'b1000_0000
  } state_t;

  state_t state_r, state_nxt;
  logic   fetch_r, fetch_nxt;

  // next state and commands
  always_comb begin
    state_nxt = state_r;
    fetch_nxt = 1'b0;
    cmd       = '0;
    in_tready = 1'b0;
    case (state_r)
      S_IDLE: begin
        in_tready  = 1'b1;
        cmd.accept = in_tvalid;
        if (in_tvalid) state_nxt = S_PLAN;
      end
      S_PLAN: begin
        case (stat.plan)
          PLAN_UP: state_nxt = S_UP_RD;
          PLAN_DN: state_nxt = S_DN_RD;
          default: begin
            cmd.rd_cur = 1'b1;
            state_nxt  = S_RESP;
          end
        endcase
      end
      S_UP_RD: begin
        if (stat.loop_more) begin
          cmd.rd_shift = 1'b1;
          state_nxt    = S_UP_WR;
        end else begin
          state_nxt = S_PUT;
        end
      end
      S_UP_WR: begin
        cmd.wr_shift = 1'b1;
        state_nxt    = S_UP_RD;
      end
      S_PUT: begin
        cmd.wr_put = 1'b1;
        fetch_nxt  = 1'b1;
        state_nxt  = S_RESP;
      end
      S_DN_RD: begin
        if (stat.loop_more) begin
          cmd.rd_shift = 1'b1;
          state_nxt    = S_DN_WR;
        end else begin
          cmd.rd_cur = 1'b1;
          state_nxt  = S_RESP;
        end
      end
      S_DN_WR: begin
        cmd.wr_shift = 1'b1;
        state_nxt    = S_DN_RD;
      end
      S_RESP: begin
        // after a put the cursor entry is read here, before the result is loaded
        if (fetch_r) begin
          cmd.rd_cur = 1'b1;
        end else if (stat.out_free) begin
          cmd.load_out = 1'b1;
          state_nxt    = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      fetch_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      fetch_r <= fetch_nxt;
    end
  end

`ifndef NO_ASSERTIONS
  a_accept_to_plan: assert property (@(posedge clk) disable iff (!rst_n)
    (in_tvalid && in_tready) |=> state_r == S_PLAN)
    else $error("accepted beat not taken to planning");

  a_single_mem_write: assert property (@(posedge clk) disable iff (!rst_n)
    !(cmd.wr_shift && cmd.wr_put))
    else $error("two memory writes in one cycle");

  a_load_after_read: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.load_out |-> !$past(cmd.wr_put))
    else $error("result loaded before cursor entry read");
`endif

endmodule

>>> src/cursor_sequence_store.sv
// cursor sequence store, top level: ordered store of values with a cursor.
// Input channel (in_*): one request per beat; req_type in in_tuser[2:0]
// (start, advance, insert, attach, remove, read), entry_value in in_tdata.
// Output channel (out_*): exactly one result beat per request, in order,
// with current_value, has_item and item_count in out_tdata and the status
// code in out_tuser.
// Insert, attach and remove run a shift loop over the item memory that
// moves each item by one place, with one read and one write per moved item;
// one request is in work at a time.
// A new input beat is taken as soon as the previous request has loaded its
// result, even while that result still waits in the output register.
// Reset (rst_n low, synchronous) empties the store and puts the cursor at
// position zero; memory contents are not cleared. When the receiver stalls
// the result holds in the output register and the next request finishes
// its work, then waits until the register frees.
// depends on css_pkg, css_ctrl and css_datapath.
`timescale 1ns / 1ps

module cursor_sequence_store #(
  parameter int unsigned DEPTH      = 32,
  parameter int unsigned VALUE_BITS = 32
) (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                in_tvalid,
  output logic                                in_tready,
  input  logic [css_pkg::IN_TDATA_BITS-1:0]   in_tdata,   // entry_value[31:0]
  input  logic [css_pkg::REQ_BITS-1:0]        in_tuser,   // req_type[2:0]
  output logic                                out_tvalid,
  input  logic                                out_tready,
  // current_value[31:0], has_item[32], item_count[38:33], zero pad[39]
  output logic [css_pkg::OUT_TDATA_BITS-1:0]  out_tdata,
  output logic [1:0]                          out_tuser   // status[1:0]
);
  import css_pkg::*;

  dp_cmd_t  cmd;
  dp_stat_t stat;

  // sequencer
  css_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .stat      (stat),
    .cmd       (cmd)
  );

  // store, cursor and output register
  css_datapath #(
    .DEPTH      (DEPTH),
    .VALUE_BITS (VALUE_BITS)
  ) u_datapath (
    .clk        (clk),
    .rst_n      (rst_n),
    .cmd        (cmd),
    .stat       (stat),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser)
  );

endmodule

>>> tb/sv/cursor_sequence_store_test.sv
// testbench for cursor_sequence_store: drives request beats, predicts each
// result with its own copy of the sequence and cursor, and checks every beat.
// depends on css_pkg and the cursor_sequence_store rtl.
`timescale 1ns / 1ps

module cursor_sequence_store_test;
  import css_pkg::*;

  localparam int unsigned STORE_DEPTH  = 32;
  localparam int unsigned RANDOM_ITEMS = 1800;
  localparam int unsigned CYCLE_LIMIT  = 800000;
  localparam int unsigned HOLD_CYCLES  = 300;
  localparam int unsigned DRAIN_CYCLES = 100;

  // request codes the block leaves unused
  localparam logic [2:0] REQ_SPARE_LO = 3'd6;
  localparam logic [2:0] REQ_SPARE_HI = 3'd7;

  typedef enum int {SEG_FILL, SEG_DRAIN, SEG_MIXED} segment_t;

  typedef struct {
    logic [2:0]  code;
    logic [31:0] value;
  } request_t;

  typedef struct {
    logic [31:0] value;
    logic        has;
    logic [5:0]  count;
    logic [1:0]  status;
  } cursor_view_t;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_tvalid = 1'b0;
  logic        in_tready;
  logic [31:0] in_tdata = '0;
  logic [2:0]  in_tuser = '0;
  logic        out_tvalid;
  logic        out_tready = 1'b0;
  logic [39:0] out_tdata;
  logic [1:0]  out_tuser;

  request_t     pending_requests[$];
  cursor_view_t expected_views[$];
  logic [31:0]  model_items[$];
  int           model_cursor = 0;

  int  total_requests = 0;
  int  accepted_requests = 0;
  int  results_seen = 0;
  int  error_count = 0;
  int  cycle_count = 0;
  int  gap_left = 0;
  int  stall_left = 0;
  bit  in_took = 1'b0;
  bit  steady = 1'b0;
  bit  hold_rx = 1'b0;

  cursor_sequence_store #(
    .DEPTH(STORE_DEPTH),
    .VALUE_BITS(32)
  ) DUT (
    .clk(clk),
    .rst_n(rst_n),
    .in_tvalid(in_tvalid),
    .in_tready(in_tready),
    .in_tdata(in_tdata),
    .in_tuser(in_tuser),
    .out_tvalid(out_tvalid),
    .out_tready(out_tready),
    .out_tdata(out_tdata),
    .out_tuser(out_tuser)
  );

  // 8 ns clock
  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  // apply one request to the sequence and return the view after it
  function automatic cursor_view_t step_sequence(logic [2:0] code, logic [31:0] value);
    cursor_view_t view;
    view.status = ST_OK;
    case (code)
      REQ_START: begin
        model_cursor = 0;
      end
      REQ_ADVANCE: begin
        if (model_cursor < model_items.size()) model_cursor++;
        else view.status = ST_NOITEM;
      end
      REQ_INSERT: begin
        if (model_items.size() >= STORE_DEPTH) begin
          view.status = ST_FULL;
        end else begin
          // no current item: new value goes to the front
          if (model_cursor >= model_items.size()) model_cursor = 0;
          model_items.insert(model_cursor, value);
        end
      end
      REQ_ATTACH: begin
        if (model_items.size() >= STORE_DEPTH) begin
          view.status = ST_FULL;
        end else begin
          // after the current item, or at the end when there is none
          if (model_cursor < model_items.size()) model_cursor++;
          else model_cursor = model_items.size();
          model_items.insert(model_cursor, value);
        end
      end
      REQ_REMOVE: begin
        if (model_cursor >= model_items.size()) view.status = ST_NOITEM;
        else model_items.delete(model_cursor);
      end
      REQ_READ: begin
        if (model_cursor >= model_items.size()) view.status = ST_NOITEM;
      end
      default: begin
      end
    endcase
    if (model_cursor < model_items.size()) begin
      view.value = model_items[model_cursor];
      view.has   = 1'b1;
    end else begin
      view.value = '0;
      view.has   = 1'b0;
    end
    view.count = 6'(model_items.size());
    return view;
  endfunction

  task automatic report_mismatch(string field_name, logic [31:0] got, logic [31:0] want);
    $display("mismatch on result %0d: %s got %0h expected %0h",
             results_seen, field_name, got, want);
    error_count++;
  endtask

  task automatic queue_request(logic [2:0] code, logic [31:0] value);
    request_t req;
    req.code  = code;
    req.value = value;
    pending_requests.push_back(req);
    total_requests++;
  endtask

  // weighted request code for one kind of random segment
  function automatic logic [2:0] pick_code(segment_t seg);
    int roll;
    roll = $urandom_range(0, 99);
    case (seg)
      SEG_FILL: begin
        if (roll < 40) return REQ_INSERT;
        if (roll < 80) return REQ_ATTACH;
        if (roll < 87) return REQ_ADVANCE;
        if (roll < 92) return REQ_START;
        if (roll < 96) return REQ_READ;
        if (roll < 98) return REQ_REMOVE;
      end
      SEG_DRAIN: begin
        if (roll < 45) return REQ_REMOVE;
        if (roll < 60) return REQ_START;
        if (roll < 75) return REQ_ADVANCE;
        if (roll < 85) return REQ_READ;
        if (roll < 91) return REQ_INSERT;
        if (roll < 97) return REQ_ATTACH;
      end
      default: begin
        if (roll < 16) return REQ_START;
        if (roll < 32) return REQ_ADVANCE;
        if (roll < 48) return REQ_INSERT;
        if (roll < 64) return REQ_ATTACH;
        if (roll < 80) return REQ_REMOVE;
        if (roll < 96) return REQ_READ;
      end
    endcase
    return ($urandom_range(0, 1) != 0) ? REQ_SPARE_HI : REQ_SPARE_LO;
  endfunction

  function automatic logic [31:0] pick_value();
    case ($urandom_range(0, 9))
      0: return 32'h0000_0000;
      1: return 32'hFFFF_FFFF;
      default: return $urandom;
    endcase
  endfunction

  // sender: holds a beat until taken, random gaps between beats
  always @(negedge clk) begin
    request_t req;
    if (!rst_n) begin
      in_tvalid <= 1'b0;
    end else if (!in_tvalid || in_took) begin
      if (gap_left > 0) begin
        gap_left  <= gap_left - 1;
        in_tvalid <= 1'b0;
      end else if (pending_requests.size() != 0) begin
        req = pending_requests.pop_front();
        in_tvalid <= 1'b1;
        in_tdata  <= req.value;
        in_tuser  <= req.code;
        if (!steady && $urandom_range(0, 5) == 0) gap_left <= $urandom_range(1, 5);
      end else begin
        in_tvalid <= 1'b0;
      end
    end
  end

  // receiver: random stall bursts, plus the long hold-off
  always @(negedge clk) begin
    if (!rst_n) begin
      out_tready <= 1'b0;
    end else if (stall_left > 0) begin
      stall_left <= stall_left - 1;
      out_tready <= 1'b0;
    end else if (hold_rx) begin
      out_tready <= 1'b0;
    end else if (!steady && $urandom_range(0, 6) == 0) begin
      stall_left <= $urandom_range(0, 4);
      out_tready <= 1'b0;
    end else begin
      out_tready <= 1'b1;
    end
  end

  // long hold-off once traffic is flowing, so the input backs up
  initial begin
    wait (results_seen >= 400);
    @(posedge clk);
    hold_rx = 1'b1;
    repeat (HOLD_CYCLES) @(posedge clk);
    hold_rx = 1'b0;
  end

  // monitor: predict on each request beat, check each result beat
  always @(posedge clk) begin
    cursor_view_t want;
    if (!rst_n) begin
      in_took = 1'b0;
    end else begin
      in_took = in_tvalid && in_tready;
      if (in_took) begin
        accepted_requests++;
        expected_views.push_back(step_sequence(in_tuser, in_tdata));
      end
      if (out_tvalid && out_tready) begin
        results_seen++;
        if (expected_views.size() == 0) begin
          report_mismatch("unexpected beat", out_tdata[31:0], '0);
        end else begin
          want = expected_views.pop_front();
          if (out_tdata[31:0] !== want.value)
            report_mismatch("current_value", out_tdata[31:0], want.value);
          if (out_tdata[32] !== want.has)
            report_mismatch("has_item", 32'(out_tdata[32]), 32'(want.has));
          if (out_tdata[38:33] !== want.count)
            report_mismatch("item_count", 32'(out_tdata[38:33]), 32'(want.count));
          if (out_tuser !== want.status)
            report_mismatch("status", 32'(out_tuser), 32'(want.status));
        end
      end
    end
  end

  // watchdog
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("Simulation FAILED");
      $finish;
    end
  end

  initial begin
    segment_t seg;
    int       seg_len;
    int       made;

    // directed: empty store cases, front and end placement, extremes
    queue_request(REQ_START, 32'h0);
    queue_request(REQ_ADVANCE, 32'h0);
    queue_request(REQ_REMOVE, 32'h0);
    queue_request(REQ_READ, 32'h0);
    queue_request(REQ_INSERT, 32'h0000_0000);
    queue_request(REQ_READ, 32'hFFFF_FFFF);
    queue_request(REQ_ATTACH, 32'hFFFF_FFFF);
    queue_request(REQ_INSERT, 32'h1234_5678);
    queue_request(REQ_START, 32'h0);
    queue_request(REQ_READ, 32'h0);
    queue_request(REQ_ADVANCE, 32'h0);
    queue_request(REQ_ADVANCE, 32'h0);
    queue_request(REQ_ADVANCE, 32'h0);
    queue_request(REQ_READ, 32'h0);
    queue_request(REQ_REMOVE, 32'h0);
    queue_request(REQ_ATTACH, 32'h8000_0001);
    queue_request(REQ_ADVANCE, 32'h0);
    queue_request(REQ_INSERT, 32'hAAAA_5555);
    queue_request(REQ_REMOVE, 32'h0);
    queue_request(REQ_SPARE_LO, 32'hDEAD_BEEF);
    queue_request(REQ_SPARE_HI, 32'h5555_AAAA);
    queue_request(REQ_START, 32'h0);
    queue_request(REQ_REMOVE, 32'h0);

    // random: segments that fill to full, drain, or mix
    made = 0;
    while (made < RANDOM_ITEMS) begin
      seg     = segment_t'($urandom_range(0, 2));
      seg_len = (seg == SEG_FILL) ? $urandom_range(30, 70) : $urandom_range(20, 60);
      repeat (seg_len) begin
        queue_request(pick_code(seg), pick_value());
        made++;
      end
    end

    repeat (6) @(negedge clk);
    rst_n <= 1'b1;

    // last stretch runs without idling
    wait (pending_requests.size() < 150);
    steady = 1'b1;

    wait (accepted_requests == total_requests);
    wait (expected_views.size() == 0);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (error_count == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule
